// ===== rtl/sct_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted client table package
// Shared constants, operation and status codes, and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int ADDR_W      = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int KEY_W       = 32;
	localparam int OP_W        = 3;
	localparam int STATUS_W    = 2;
	localparam int ENTRY_W     = 2 * KEY_W;
	localparam int IN_FIELDS_W = OP_W + 2 * KEY_W;
	localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = STATUS_W + ADDR_W + CNT_W;
	localparam int OUT_DATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_ADD       = 3'd0,
		OP_DEL_USER  = 3'd1,
		OP_DEL_CONN  = 3'd2,
		OP_FIND_USER = 3'd3,
		OP_FIND_CONN = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic take;
		logic first;
		logic scan;
		logic put;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic go_done;
		logic go_put;
	} stat_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_client_table.sv =====
// ----------------------------------------------------------------------------
// Sorted client table
// Table of (user id, connection id) pairs kept in ascending signed user id
// order, with add, delete and search by either key.
// ----------------------------------------------------------------------------
// Throughput: one item at a time; a new item is taken only after the result
// of the last one is loaded. A scan reads one entry per cycle through the
// single read port of the entry memory and may walk the whole table.
// Reset clears the live count and the handshake state, not the entry memory.
`timescale 1ns / 1ps
`default_nettype none

module sorted_client_table (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// operation [2:0], user_key [34:3], conn_key [66:35], zero padding above.
	input  wire logic [sct_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// status [1:0], position [7:2], entry_count [14:8], zero padding above.
	output logic [sct_pkg::OUT_DATA_W-1:0]        m_tdata
);

	sct_pkg::cmd_t  cmd;
	sct_pkg::stat_t stat;

	logic [sct_pkg::STATUS_W-1:0] status;
	logic [sct_pkg::ADDR_W-1:0]   position;
	logic [sct_pkg::CNT_W-1:0]    entry_count;

	sct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	sct_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.operation   (s_tdata[sct_pkg::OP_W-1:0]),
		.user_key    (s_tdata[sct_pkg::OP_W+sct_pkg::KEY_W-1:sct_pkg::OP_W]),
		.conn_key    (s_tdata[sct_pkg::IN_FIELDS_W-1:sct_pkg::OP_W+sct_pkg::KEY_W]),
		.status      (status),
		.position    (position),
		.entry_count (entry_count)
	);

	assign m_tdata = {{(sct_pkg::OUT_DATA_W - sct_pkg::OUT_FIELDS_W){1'b0}},
		entry_count, position, status};

`ifndef SYNTH
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("More than one datapath command in a cycle.");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (status != sct_pkg::ST_OK) |-> (position == '0))
		else $error("Position is not zero on a failed operation.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (entry_count <= sct_pkg::CNT_W'(sct_pkg::MAX_ENTRIES)))
		else $error("Entry count exceeds the table size.");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("A second item was taken while one is in work.");
`endif

endmodule

`default_nettype wire

// ===== rtl/sct_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted client table controller
// Sequences one item at a time through setup, scan, insert and result load,
// and owns the valid flag of the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sct_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output sct_pkg::cmd_t      cmd,
	input  wire sct_pkg::stat_t stat
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_SCAN,
		S_PUT,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd.take  = (state_q == S_IDLE) && in_valid;
		cmd.first = (state_q == S_LOAD);
		cmd.scan  = (state_q == S_SCAN);
		cmd.put   = (state_q == S_PUT);
		cmd.load  = (state_q == S_DONE) && (!out_valid_q || out_ready);
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_LOAD;
				end
				S_LOAD, S_SCAN: begin
					if (stat.go_done) state_q <= S_DONE;
					else if (stat.go_put) state_q <= S_PUT;
					else state_q <= S_SCAN;
				end
				S_PUT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (cmd.load) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sct_datapath.sv =====
// ----------------------------------------------------------------------------
// Sorted client table datapath
// Entry memory with a registered read port, key registers, live count, the
// scan compare and shift logic, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sct_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire sct_pkg::cmd_t                     cmd,
	output sct_pkg::stat_t                         stat,
	input  wire logic [sct_pkg::OP_W-1:0]          operation,
	input  wire logic signed [sct_pkg::KEY_W-1:0]  user_key,
	input  wire logic signed [sct_pkg::KEY_W-1:0]  conn_key,
	output logic [sct_pkg::STATUS_W-1:0]           status,
	output logic [sct_pkg::ADDR_W-1:0]             position,
	output logic [sct_pkg::CNT_W-1:0]              entry_count
);

	logic [sct_pkg::ENTRY_W-1:0] entry_mem [sct_pkg::MAX_ENTRIES];
	logic [sct_pkg::ENTRY_W-1:0] rdata_q;
	logic [sct_pkg::ADDR_W-1:0]  rd_addr;
	logic [sct_pkg::ADDR_W-1:0]  wr_addr;
	logic [sct_pkg::ENTRY_W-1:0] wr_data;
	logic                        wr_en;

	logic [sct_pkg::OP_W-1:0]         op_q;
	logic signed [sct_pkg::KEY_W-1:0] ukey_q;
	logic signed [sct_pkg::KEY_W-1:0] ckey_q;
	logic [sct_pkg::CNT_W-1:0]        count_q;
	logic [sct_pkg::CNT_W-1:0]        count_d;
	logic [sct_pkg::ADDR_W-1:0]       idx_q, idx_d;
	logic [sct_pkg::ADDR_W-1:0]       put_pos_q, put_pos_d;
	logic [sct_pkg::ADDR_W-1:0]       pos_q, pos_d;
	logic                             found_q, found_d;
	sct_pkg::status_t                 res_q, res_d;

	logic [sct_pkg::STATUS_W-1:0] status_q;
	logic [sct_pkg::ADDR_W-1:0]   position_q;
	logic [sct_pkg::CNT_W-1:0]    entry_count_q;

	logic signed [sct_pkg::KEY_W-1:0] rd_user;
	logic signed [sct_pkg::KEY_W-1:0] rd_conn;
	logic                             is_add, is_del, by_user;
	logic                             match, greater, idx_last;
	logic [sct_pkg::ADDR_W-1:0]       count_top;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem[wr_addr] <= wr_data;
		end
		rdata_q <= entry_mem[rd_addr];
	end

	assign rd_user   = rdata_q[sct_pkg::KEY_W-1:0];
	assign rd_conn   = rdata_q[sct_pkg::ENTRY_W-1:sct_pkg::KEY_W];
	assign is_add    = (op_q == sct_pkg::OP_ADD);
	assign is_del    = op_q inside {sct_pkg::OP_DEL_USER, sct_pkg::OP_DEL_CONN};
	assign by_user   = op_q inside {sct_pkg::OP_DEL_USER, sct_pkg::OP_FIND_USER};
	assign match     = by_user ? (rd_user == ukey_q) : (rd_conn == ckey_q);
	assign greater   = (rd_user > ukey_q);
	assign idx_last  = ((sct_pkg::CNT_W'(idx_q) + sct_pkg::CNT_W'(1)) == count_q);
	assign count_top = sct_pkg::ADDR_W'(count_q - sct_pkg::CNT_W'(1));

	always_comb begin
		idx_d     = idx_q;
		put_pos_d = put_pos_q;
		pos_d     = pos_q;
		found_d   = found_q;
		res_d     = res_q;
		rd_addr   = idx_q;
		wr_en     = 1'b0;
		wr_addr   = idx_q;
		wr_data   = rdata_q;
		stat      = '0;
		if (cmd.first) begin
			res_d   = sct_pkg::ST_NOT_FOUND;
			found_d = 1'b0;
			pos_d   = '0;
			case (op_q)
				sct_pkg::OP_ADD: begin
					if (count_q >= sct_pkg::CNT_W'(sct_pkg::MAX_ENTRIES)) begin
						res_d        = sct_pkg::ST_FULL;
						stat.go_done = 1'b1;
					end else if (count_q == '0) begin
						put_pos_d   = '0;
						stat.go_put = 1'b1;
					end else begin
						rd_addr = count_top;
						idx_d   = count_top;
					end
				end
				sct_pkg::OP_DEL_USER, sct_pkg::OP_DEL_CONN: begin
					if (count_q == '0) begin
						res_d        = sct_pkg::ST_EMPTY;
						stat.go_done = 1'b1;
					end else begin
						rd_addr = '0;
						idx_d   = '0;
					end
				end
				sct_pkg::OP_FIND_USER, sct_pkg::OP_FIND_CONN: begin
					if (count_q == '0) begin
						stat.go_done = 1'b1;
					end else begin
						rd_addr = '0;
						idx_d   = '0;
					end
				end
				default: begin
					stat.go_done = 1'b1;
				end
			endcase
		end else if (cmd.scan) begin
			if (is_add) begin
				if (greater) begin
					wr_en   = 1'b1;
					wr_addr = idx_q + sct_pkg::ADDR_W'(1);
					if (idx_q == '0) begin
						put_pos_d   = '0;
						stat.go_put = 1'b1;
					end else begin
						rd_addr = idx_q - sct_pkg::ADDR_W'(1);
						idx_d   = idx_q - sct_pkg::ADDR_W'(1);
					end
				end else begin
					put_pos_d   = idx_q + sct_pkg::ADDR_W'(1);
					stat.go_put = 1'b1;
				end
			end else begin
				if (found_q && is_del) begin
					wr_en   = 1'b1;
					wr_addr = idx_q - sct_pkg::ADDR_W'(1);
				end
				if (!found_q && match) begin
					found_d = 1'b1;
					pos_d   = idx_q;
				end
				if ((!is_del && match) || idx_last) begin
					stat.go_done = 1'b1;
					res_d = (found_q || match) ? sct_pkg::ST_OK : sct_pkg::ST_NOT_FOUND;
				end else begin
					rd_addr = idx_q + sct_pkg::ADDR_W'(1);
					idx_d   = idx_q + sct_pkg::ADDR_W'(1);
				end
			end
		end else if (cmd.put) begin
			wr_en   = 1'b1;
			wr_addr = put_pos_q;
			wr_data = {ckey_q, ukey_q};
			res_d   = sct_pkg::ST_OK;
			pos_d   = put_pos_q;
		end
	end

	always_comb begin
		count_d = count_q;
		if (res_q == sct_pkg::ST_OK) begin
			if (is_add) count_d = count_q + sct_pkg::CNT_W'(1);
			else if (is_del) count_d = count_q - sct_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q   <= operation;
			ukey_q <= user_key;
			ckey_q <= conn_key;
		end
		idx_q     <= idx_d;
		put_pos_q <= put_pos_d;
		pos_q     <= pos_d;
		found_q   <= found_d;
		res_q     <= res_d;
		if (cmd.load) begin
			status_q      <= res_q;
			position_q    <= (res_q == sct_pkg::ST_OK) ? pos_q : '0;
			entry_count_q <= count_d;
		end
	end

	assign status      = status_q;
	assign position    = position_q;
	assign entry_count = entry_count_q;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Sorted client table testbench
// Drives add, delete and search requests into the table over the input
// stream and checks every reply against a behavioural copy of the table.
// A short directed run covers an empty table, the key extremes,
// duplicate user ids and the unused operation codes. A random run then
// fills and drains the table several times, with random gaps and stalls on
// both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import sct_pkg::*;

	localparam int LIMIT        = 400000;
	localparam int SETTLE       = MAX_ENTRIES + 8;
	localparam int RANDOM_ITEMS = 500;
	localparam int SPARE_LO     = OP_FIND_CONN + 1;
	localparam int SPARE_HI     = (1 << OP_W) - 1;

	typedef struct packed {
		status_t             status;
		logic [ADDR_W-1:0]   position;
		logic [CNT_W-1:0]    entries;
	} reply_t;

	class client_table_model;
		logic signed [KEY_W-1:0] user_ids [MAX_ENTRIES];
		logic signed [KEY_W-1:0] conn_ids [MAX_ENTRIES];
		int     count;
		int     failures;
		reply_t due_replies [$];

		function new();
			count    = 0;
			failures = 0;
		endfunction

		function int find_first(bit by_user, logic signed [KEY_W-1:0] key);
			int hit;
			hit = count;
			for (int i = count - 1; i >= 0; i--) begin
				if ((by_user ? user_ids[i] : conn_ids[i]) == key)
					hit = i;
			end
			return hit;
		endfunction

		function void take_request(logic [IN_DATA_W-1:0] data);
			logic [OP_W-1:0]         op;
			logic signed [KEY_W-1:0] ukey;
			logic signed [KEY_W-1:0] ckey;
			reply_t                  r;
			int                      at;
			op       = data[OP_W-1:0];
			ukey     = data[OP_W +: KEY_W];
			ckey     = data[OP_W + KEY_W +: KEY_W];
			r.status = ST_NOT_FOUND;
			at       = 0;
			case (op)
				OP_ADD: begin
					if (count >= MAX_ENTRIES) begin
						r.status = ST_FULL;
					end else begin
						at = count;
						for (int i = count - 1; i >= 0; i--) begin
							if (user_ids[i] > ukey)
								at = i;
						end
						for (int i = count; i > at; i--) begin
							user_ids[i] = user_ids[i-1];
							conn_ids[i] = conn_ids[i-1];
						end
						user_ids[at] = ukey;
						conn_ids[at] = ckey;
						count++;
						r.status = ST_OK;
					end
				end
				OP_DEL_USER, OP_DEL_CONN: begin
					if (count == 0) begin
						r.status = ST_EMPTY;
					end else begin
						at = find_first(op == OP_DEL_USER, (op == OP_DEL_USER) ? ukey : ckey);
						if (at < count) begin
							for (int i = at; i + 1 < count; i++) begin
								user_ids[i] = user_ids[i+1];
								conn_ids[i] = conn_ids[i+1];
							end
							count--;
							r.status = ST_OK;
						end
					end
				end
				OP_FIND_USER, OP_FIND_CONN: begin
					at = find_first(op == OP_FIND_USER, (op == OP_FIND_USER) ? ukey : ckey);
					if (at < count)
						r.status = ST_OK;
				end
				default: ;
			endcase
			if (r.status != ST_OK)
				at = 0;
			r.position = at[ADDR_W-1:0];
			r.entries  = count[CNT_W-1:0];
			due_replies.push_back(r);
		endfunction

		function void check_reply(logic [OUT_DATA_W-1:0] data);
			reply_t got;
			reply_t want;
			got.status   = status_t'(data[STATUS_W-1:0]);
			got.position = data[STATUS_W +: ADDR_W];
			got.entries  = data[STATUS_W + ADDR_W +: CNT_W];
			if (due_replies.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected reply: status %0d position %0d entries %0d",
						got.status, got.position, got.entries);
				return;
			end
			want = due_replies.pop_front();
			if (got.status !== want.status || got.position !== want.position ||
					got.entries !== want.entries) begin
				failures++;
				if (failures <= 10)
					$display("mismatch: expected status %0d position %0d entries %0d, got status %0d position %0d entries %0d",
						want.status, want.position, want.entries,
						got.status, got.position, got.entries);
			end
		endfunction
	endclass

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  calm     = 1'b0;
	int                    cycles   = 0;

	client_table_model table_model = new();

	sorted_client_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// Mostly keys already in the table or from a narrow band, so that
	// duplicates and hits are common; the rest span the full range.
	function automatic logic [KEY_W-1:0] pick_key(bit by_user);
		int roll;
		int slot;
		roll = $urandom_range(0, 9);
		if (roll < 4 && table_model.count > 0) begin
			slot = $urandom_range(0, table_model.count - 1);
			return by_user ? table_model.user_ids[slot] : table_model.conn_ids[slot];
		end
		if (roll < 7)
			return KEY_W'($urandom_range(0, 16) - 8);
		return $urandom;
	endfunction

	task automatic send_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] ukey,
			logic [KEY_W-1:0] ckey);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_DATA_W'({ckey, ukey, op});
		do @(posedge clk); while (!s_tready);
		table_model.take_request(s_tdata);
	endtask

	initial begin : reply_sink
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 8);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			table_model.check_reply(m_tdata);
		end
	end

	initial begin : stimulus
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] ukey;
		logic [KEY_W-1:0] ckey;
		int               roll;
		int               full_tries;
		int               empty_tries;
		bit               filling;
		full_tries  = 0;
		empty_tries = 0;
		filling     = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(OP_FIND_USER, 32'd0, 32'd0);
		send_request(OP_FIND_CONN, 32'hFFFF_FFFF, 32'd0);
		send_request(OP_DEL_USER, 32'd0, 32'd0);
		send_request(OP_DEL_CONN, 32'd0, 32'd0);
		for (int c = SPARE_LO; c <= SPARE_HI; c++)
			send_request(OP_W'(c), 32'd1, 32'd1);
		send_request(OP_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_ADD, 32'h8000_0000, 32'h0000_0000);
		send_request(OP_ADD, 32'd0, 32'd5);
		send_request(OP_ADD, 32'd0, 32'd6);
		send_request(OP_ADD, 32'hFFFF_FFFF, 32'h8000_0000);
		send_request(OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_request(OP_FIND_USER, 32'd0, 32'd0);
		send_request(OP_FIND_CONN, 32'd0, 32'd6);
		send_request(OP_FIND_USER, 32'd12345, 32'd0);
		send_request(OP_DEL_CONN, 32'd0, 32'h8000_0000);
		send_request(OP_DEL_USER, 32'd0, 32'd0);
		send_request(OP_DEL_USER, 32'd999, 32'd0);
		send_request(OP_DEL_CONN, 32'd0, 32'd999);
		send_request(OP_FIND_CONN, 32'd0, 32'hFFFF_FFFF);
		send_request(OP_W'(SPARE_HI), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_DEL_USER, 32'h8000_0000, 32'd0);

		// Alternate between filling the table past full and draining it
		// past empty, so that both ends are reached repeatedly.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 32 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (filling && table_model.count == MAX_ENTRIES) begin
				full_tries++;
				if (full_tries > 3) begin
					filling    = 1'b0;
					full_tries = 0;
				end
			end else if (!filling && table_model.count == 0) begin
				empty_tries++;
				if (empty_tries > 3) begin
					filling     = 1'b1;
					empty_tries = 0;
				end
			end
			roll = $urandom_range(0, 99);
			if (roll < 3)
				op = OP_W'($urandom_range(SPARE_LO, SPARE_HI));
			else if (roll < 15)
				op = $urandom_range(0, 1) ? OP_FIND_USER : OP_FIND_CONN;
			else if ((roll < 85) == filling)
				op = OP_ADD;
			else
				op = $urandom_range(0, 1) ? OP_DEL_USER : OP_DEL_CONN;
			ukey = pick_key(1'b1);
			ckey = pick_key(1'b0);
			send_request(op, ukey, ckey);
		end

		s_tvalid <= 1'b0;
		while (table_model.due_replies.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (table_model.failures == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
